>>> rtl/mbt_pkg.sv
// ----------------------------------------------------------------------------
// mbt_pkg: shared constants, types and functions
// Network sizes, parameter map, opcodes, sigmoid table and memory request type.
// ----------------------------------------------------------------------------
package mbt_pkg;

  localparam int NUM_FEATURES = 3;
  localparam int NUM_HIDDEN   = 10;
  localparam int NUM_WEIGHTS  = NUM_FEATURES * NUM_HIDDEN;
  localparam int OW_BASE      = NUM_WEIGHTS;
  localparam int HB_BASE      = OW_BASE + NUM_HIDDEN;
  localparam int OB_INDEX     = HB_BASE + NUM_HIDDEN;
  localparam int NUM_PARAMS   = OB_INDEX + 1;

  localparam int AW   = $clog2(NUM_PARAMS);
  localparam int JW   = (NUM_HIDDEN > 1) ? $clog2(NUM_HIDDEN) : 1;
  localparam int XW   = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
  localparam int IW   = $clog2(NUM_FEATURES + 1);
  localparam int KMAX = ((NUM_FEATURES > NUM_HIDDEN) ? NUM_FEATURES : NUM_HIDDEN) + 1;
  localparam int KW   = $clog2(KMAX + 1);

  localparam logic [12:0] RATE_RESET = 13'd3686;

  localparam logic [63:0] ONE_Q30      = 64'd1073741824;
  localparam logic [63:0] EXP_STEP_Q30 = 64'd1008687096;

  typedef enum logic [1:0] {
    OP_INFER = 2'd0,
    OP_TRAIN = 2'd1,
    OP_WRITE = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_RATE_HW = 2'd0,
    CFG_RATE_OW = 2'd1,
    CFG_RATE_HB = 2'd2,
    CFG_RATE_OB = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic                we;
    logic [AW-1:0]       waddr;
    logic signed [15:0]  wdata;
    logic [AW-1:0]       raddr;
  } mem_req_t;

  typedef logic [12:0] sig_tab_t [256];

  // shift-subtract divide, elaboration use only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic sig_tab_t build_sig_table();
    sig_tab_t    tab;
    logic [31:0] half [129];
    logic [63:0] p;
    logic [63:0] den;
    p = ONE_Q30;
    for (int k = 0; k <= 128; k++) begin
      den = ONE_Q30 + p;
      half[k] = 32'(udiv64((64'd4096 << 30) + (den >> 1), den));
      p = (p * EXP_STEP_Q30 + (64'd1 << 29)) >> 30;
    end
    for (int k = 0; k < 256; k++) begin
      if (k >= 128) begin
        tab[k] = 13'(half[k-128]);
      end else begin
        tab[k] = 13'(32'd4096 - half[128-k]);
      end
    end
    return tab;
  endfunction

  localparam sig_tab_t SIG_TABLE = build_sig_table();

  function automatic logic [12:0] sig_lookup(input logic signed [27:0] pre);
    logic [27:0] off;
    off = 28'(pre + 28'sd32768);
    if (pre < -28'sd32768) begin
      return SIG_TABLE[0];
    end else if (pre > 28'sd32767) begin
      return SIG_TABLE[255];
    end
    return SIG_TABLE[off[15:8]];
  endfunction

endpackage

>>> rtl/mbt_param_mem.sv
// ----------------------------------------------------------------------------
// mbt_param_mem: weight and bias store
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mbt_param_mem
  import mbt_pkg::*;
(
  input  logic               clk_i,
  input  mem_req_t           req_i,
  output logic signed [15:0] rdata_o
);

  logic signed [15:0] mem [NUM_PARAMS];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.raddr];
  end

endmodule

>>> rtl/mlp_backprop_trainer.sv
// ----------------------------------------------------------------------------
// mlp_backprop_trainer: 3-10-1 sigmoid perceptron with online backprop
// Q4.12 inference, one-sample SGD training, parameter writes, error clear.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Its single result
// beat shows on net_output_o and loss_o for one cycle with done_o high; the
// receiver cannot stall, so sample it then. Write and clear commands give
// their beat on the next cycle. In training each weight or bias is read,
// multiplied and written back in its own steps. Weights and biases hold
// garbage until written with the write opcode. Rates must change only while
// idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module mlp_backprop_trainer
  import mbt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode_i,
  input  logic signed [15:0] feature_a_i,
  input  logic signed [15:0] feature_b_i,
  input  logic signed [15:0] feature_c_i,
  input  logic [12:0]        target_i,
  input  logic [5:0]         param_index_i,
  input  logic signed [15:0] param_value_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [12:0]        cfg_wdata_i,
  output logic               done_o,
  output logic [12:0]        net_output_o,
  output logic [30:0]        loss_o
);

  typedef enum logic [20:0] {
    S_IDLE   = 21'h000001,
    S_HACC   = 21'h000002,
    S_HACT   = 21'h000004,
    S_OACC   = 21'h000008,
    S_OACT   = 21'h000010,
    S_Q1     = 21'h000020,
    S_Q2     = 21'h000040,
    S_Q3     = 21'h000080,
    S_OW_RD  = 21'h000100,
    S_OW_MUL = 21'h000200,
    S_OW_WR  = 21'h000400,
    S_PP1    = 21'h000800,
    S_PP2    = 21'h001000,
    S_PP3    = 21'h002000,
    S_UP_RD  = 21'h004000,
    S_UP_MUL = 21'h008000,
    S_UP_WR  = 21'h010000,
    S_OB_RD  = 21'h020000,
    S_OB_MUL = 21'h040000,
    S_OB_WR  = 21'h080000,
    S_SPARE  = 21'h100000
  } state_e;

  // saturating parameter update: w + round(p >> 12 or 24)
  function automatic logic signed [15:0] upd_param(input logic signed [15:0] w,
                                                   input logic signed [47:0] p,
                                                   input logic               short_shift);
    logic signed [47:0] r;
    logic signed [48:0] s;
    r = short_shift ? ((p + 48'sd2048) >>> 12) : ((p + 48'sd8388608) >>> 24);
    s = 49'(w) + 49'(r);
    if (s > 49'sd32767) begin
      return 16'sh7fff;
    end else if (s < -49'sd32768) begin
      return 16'sh8000;
    end
    return s[15:0];
  endfunction

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic [JW-1:0] j_q, j_d;
  logic [KW-1:0] k_q, k_d;
  logic [IW-1:0] i_q, i_d;
  logic done_q, done_d;
  logic [31:0] err_q, err_d;
  logic [12:0] rate_hw_q, rate_ow_q, rate_hb_q, rate_ob_q;

  logic signed [15:0] x_q [NUM_FEATURES];
  logic signed [15:0] x_d [NUM_FEATURES];
  logic [12:0]        h_q [NUM_HIDDEN];
  logic [12:0]        h_d [NUM_HIDDEN];
  logic [12:0]        t_q, t_d, y_q, y_d;
  logic signed [39:0] acc_q, acc_d;
  logic signed [27:0] pa_q, pa_d;
  logic [26:0]        dsq_q, dsq_d;
  logic signed [15:0] qq_q, qq_d;
  logic signed [29:0] rqo_q, rqo_d, rqb_q, rqb_d;
  logic signed [15:0] wold_q, wold_d;
  logic signed [47:0] prod_q, prod_d;
  logic [25:0]        hh_q, hh_d;
  logic signed [15:0] ownew_q, ownew_d;
  logic signed [31:0] t1_q, t1_d;
  logic signed [15:0] pp_q, pp_d;
  logic signed [29:0] rph_q, rph_d, rpb_q, rpb_d;

  mem_req_t           mreq;
  logic signed [15:0] rdata;

  // shared read points
  logic [XW-1:0]      xidx;
  logic signed [15:0] x_sel;
  logic [12:0]        h_sel;
  logic signed [27:0] pre;
  logic [12:0]        act;
  logic signed [13:0] diff;
  logic signed [41:0] qfull;
  logic signed [58:0] t2;
  logic signed [15:0] wnew;
  logic [32:0]        esum;

  mbt_param_mem u_mem (
    .clk_i  (clk_i),
    .req_i  (mreq),
    .rdata_o(rdata)
  );

  assign busy         = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign net_output_o = y_q;
  assign loss_o       = err_q[31:1];

  assign xidx  = (state_q == S_HACC) ? XW'(k_q - KW'(2)) : XW'(i_q);
  assign x_sel = x_q[xidx];
  assign h_sel = h_q[j_q];
  assign pre   = 28'((acc_q + 40'sd2048) >>> 12);
  assign act   = sig_lookup(pre);
  assign diff  = $signed({1'b0, t_q}) - $signed({1'b0, y_q});
  assign qfull = pa_q * $signed(14'(14'd4096 - {1'b0, y_q}));
  assign t2    = t1_q * $signed({1'b0, hh_q});
  assign wnew  = upd_param(wold_q, prod_q,
                           (state_q == S_UP_WR) ? (i_q == IW'(NUM_FEATURES))
                                                : (state_q == S_OB_WR));
  assign esum  = {1'b0, err_q} + 33'(dsq_q);

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    j_d     = j_q;
    k_d     = k_q;
    i_d     = i_q;
    done_d  = 1'b0;
    err_d   = err_q;
    x_d     = x_q;
    h_d     = h_q;
    t_d     = t_q;
    y_d     = y_q;
    acc_d   = acc_q;
    pa_d    = pa_q;
    dsq_d   = dsq_q;
    qq_d    = qq_q;
    rqo_d   = rqo_q;
    rqb_d   = rqb_q;
    wold_d  = wold_q;
    prod_d  = prod_q;
    hh_d    = hh_q;
    ownew_d = ownew_q;
    t1_d    = t1_q;
    pp_d    = pp_q;
    rph_d   = rph_q;
    rpb_d   = rpb_q;
    mreq    = '0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d = op_e'(opcode_i);
          t_d  = target_i;
          for (int n = 0; n < NUM_FEATURES; n++) begin
            if (n == 0) begin
              x_d[n] = feature_a_i;
            end else if (n == 1) begin
              x_d[n] = feature_b_i;
            end else if (n == 2) begin
              x_d[n] = feature_c_i;
            end else begin
              x_d[n] = '0;
            end
          end
          case (op_e'(opcode_i))
            OP_INFER, OP_TRAIN: begin
              j_d     = '0;
              k_d     = '0;
              state_d = S_HACC;
            end
            OP_WRITE: begin
              if (32'(param_index_i) < NUM_PARAMS) begin
                mreq.we    = 1'b1;
                mreq.waddr = AW'(param_index_i);
                mreq.wdata = param_value_i;
              end
              y_d    = '0;
              done_d = 1'b1;
            end
            default: begin
              err_d  = '0;
              y_d    = '0;
              done_d = 1'b1;
            end
          endcase
        end
      end

      // hidden pre-activation: bias, then one weight per cycle
      S_HACC: begin
        if (k_q == '0) begin
          mreq.raddr = AW'(HB_BASE) + AW'(j_q);
        end else if (k_q <= KW'(NUM_FEATURES)) begin
          mreq.raddr = AW'(k_q - KW'(1)) * AW'(NUM_HIDDEN) + AW'(j_q);
        end
        if (k_q == KW'(1)) begin
          acc_d = 40'(rdata) <<< 12;
        end else if (k_q >= KW'(2)) begin
          acc_d = acc_q + 40'(rdata * x_sel);
        end
        if (k_q == KW'(NUM_FEATURES + 1)) begin
          k_d     = '0;
          state_d = S_HACT;
        end else begin
          k_d = k_q + KW'(1);
        end
      end

      S_HACT: begin
        h_d[j_q] = act;
        if (j_q == JW'(NUM_HIDDEN - 1)) begin
          j_d     = '0;
          state_d = S_OACC;
        end else begin
          j_d     = j_q + JW'(1);
          state_d = S_HACC;
        end
      end

      // output pre-activation; j tracks the hidden node on the data side
      S_OACC: begin
        if (k_q == '0) begin
          mreq.raddr = AW'(OB_INDEX);
        end else if (k_q <= KW'(NUM_HIDDEN)) begin
          mreq.raddr = AW'(OW_BASE) + AW'(k_q - KW'(1));
        end
        if (k_q == KW'(1)) begin
          acc_d = 40'(rdata) <<< 12;
        end else if (k_q >= KW'(2)) begin
          acc_d = acc_q + 40'(rdata * $signed({1'b0, h_sel}));
          j_d   = (j_q == JW'(NUM_HIDDEN - 1)) ? '0 : j_q + JW'(1);
        end
        if (k_q == KW'(NUM_HIDDEN + 1)) begin
          k_d     = '0;
          state_d = S_OACT;
        end else begin
          k_d = k_q + KW'(1);
        end
      end

      S_OACT: begin
        y_d = act;
        if (op_q == OP_INFER) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_Q1;
        end
      end

      S_Q1: begin
        pa_d    = diff * $signed({1'b0, y_q});
        dsq_d   = 27'(diff * diff);
        state_d = S_Q2;
      end

      S_Q2: begin
        qq_d    = 16'((qfull + 42'sd8388608) >>> 24);
        state_d = S_Q3;
      end

      S_Q3: begin
        rqo_d   = $signed({1'b0, rate_ow_q}) * qq_q;
        rqb_d   = $signed({1'b0, rate_ob_q}) * qq_q;
        j_d     = '0;
        state_d = S_OW_RD;
      end

      S_OW_RD: begin
        mreq.raddr = AW'(OW_BASE) + AW'(j_q);
        state_d    = S_OW_MUL;
      end

      S_OW_MUL: begin
        wold_d  = rdata;
        prod_d  = 48'(rqo_q * $signed({1'b0, h_sel}));
        hh_d    = 26'(h_sel * (13'd4096 - h_sel));
        state_d = S_OW_WR;
      end

      S_OW_WR: begin
        mreq.we    = 1'b1;
        mreq.waddr = AW'(OW_BASE) + AW'(j_q);
        mreq.wdata = wnew;
        ownew_d    = wnew;
        state_d    = S_PP1;
      end

      // hidden delta uses the freshly updated output weight
      S_PP1: begin
        t1_d    = qq_q * ownew_q;
        state_d = S_PP2;
      end

      S_PP2: begin
        pp_d    = 16'((t2 + (59'sd1 <<< 35)) >>> 36);
        state_d = S_PP3;
      end

      S_PP3: begin
        rph_d   = $signed({1'b0, rate_hw_q}) * pp_q;
        rpb_d   = $signed({1'b0, rate_hb_q}) * pp_q;
        i_d     = '0;
        state_d = S_UP_RD;
      end

      // i below NUM_FEATURES: hidden weights of node j; i at NUM_FEATURES: its bias
      S_UP_RD: begin
        if (i_q == IW'(NUM_FEATURES)) begin
          mreq.raddr = AW'(HB_BASE) + AW'(j_q);
        end else begin
          mreq.raddr = AW'(i_q) * AW'(NUM_HIDDEN) + AW'(j_q);
        end
        state_d = S_UP_MUL;
      end

      S_UP_MUL: begin
        wold_d = rdata;
        if (i_q == IW'(NUM_FEATURES)) begin
          prod_d = 48'(rpb_q);
        end else begin
          prod_d = 48'(rph_q * x_sel);
        end
        state_d = S_UP_WR;
      end

      S_UP_WR: begin
        mreq.we    = 1'b1;
        mreq.wdata = wnew;
        if (i_q == IW'(NUM_FEATURES)) begin
          mreq.waddr = AW'(HB_BASE) + AW'(j_q);
          i_d        = '0;
          if (j_q == JW'(NUM_HIDDEN - 1)) begin
            j_d     = '0;
            state_d = S_OB_RD;
          end else begin
            j_d     = j_q + JW'(1);
            state_d = S_OW_RD;
          end
        end else begin
          mreq.waddr = AW'(i_q) * AW'(NUM_HIDDEN) + AW'(j_q);
          i_d        = i_q + IW'(1);
          state_d    = S_UP_RD;
        end
      end

      S_OB_RD: begin
        mreq.raddr = AW'(OB_INDEX);
        state_d    = S_OB_MUL;
      end

      S_OB_MUL: begin
        wold_d  = rdata;
        prod_d  = 48'(rqb_q);
        state_d = S_OB_WR;
      end

      S_OB_WR: begin
        mreq.we    = 1'b1;
        mreq.waddr = AW'(OB_INDEX);
        mreq.wdata = wnew;
        err_d      = esum[32] ? 32'hffff_ffff : esum[31:0];
        done_d     = 1'b1;
        state_d    = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      op_q      <= OP_INFER;
      j_q       <= '0;
      k_q       <= '0;
      i_q       <= '0;
      done_q    <= 1'b0;
      err_q     <= '0;
      rate_hw_q <= RATE_RESET;
      rate_ow_q <= RATE_RESET;
      rate_hb_q <= RATE_RESET;
      rate_ob_q <= RATE_RESET;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      j_q     <= j_d;
      k_q     <= k_d;
      i_q     <= i_d;
      done_q  <= done_d;
      err_q   <= err_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_RATE_HW: rate_hw_q <= cfg_wdata_i;
          CFG_RATE_OW: rate_ow_q <= cfg_wdata_i;
          CFG_RATE_HB: rate_hb_q <= cfg_wdata_i;
          default:     rate_ob_q <= cfg_wdata_i;
        endcase
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    h_q     <= h_d;
    t_q     <= t_d;
    y_q     <= y_d;
    acc_q   <= acc_d;
    pa_q    <= pa_d;
    dsq_q   <= dsq_d;
    qq_q    <= qq_d;
    rqo_q   <= rqo_d;
    rqb_q   <= rqb_d;
    wold_q  <= wold_d;
    prod_q  <= prod_d;
    hh_q    <= hh_d;
    ownew_q <= ownew_d;
    t1_q    <= t1_d;
    pp_q    <= pp_d;
    rph_q   <= rph_d;
    rpb_q   <= rpb_d;
  end

endmodule

>>> rtl/mbt_checker.sv
// ----------------------------------------------------------------------------
// mbt_checker: port-level checks for mlp_backprop_trainer
// Command acceptance, result beat timing and output range.
// ----------------------------------------------------------------------------
module mbt_checker
  import mbt_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [1:0]  opcode_i,
  input logic        done_o,
  input logic [12:0] net_output_o
);

  // write and clear finish at once with a zero output
  a_quick_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (opcode_i == OP_WRITE || opcode_i == OP_CLEAR)
    |=> done_o && !busy && (net_output_o == 13'd0))
    else $error("write/clear beat missing");

  // network passes occupy the block and give no beat on the next cycle
  a_pass_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (opcode_i == OP_INFER || opcode_i == OP_TRAIN)
    |=> busy && !done_o)
    else $error("pass not started");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (net_output_o <= 13'd4096))
    else $error("sigmoid output out of range");

  // a beat comes only from work in flight or a command just taken
  a_beat_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy) || $past(start)))
    else $error("spurious result beat");

endmodule

bind mlp_backprop_trainer mbt_checker u_mbt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .opcode_i    (opcode_i),
  .done_o      (done_o),
  .net_output_o(net_output_o)
);

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for mlp_backprop_trainer
// Commands are queued by the sequence block and issued by a clocked driver.
// A built-in network model predicts net_output and loss for every accepted
// command, and a clocked monitor checks each done beat against the oldest
// prediction. There are four phases, each with its own learning rates and
// sender idling.
// ----------------------------------------------------------------------------
module tb_top;
  import mbt_pkg::*;

  localparam int CLK_PERIOD = 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEMS_PER_PHASE = 65;

  typedef struct {
    op_e         op;
    logic [15:0] fa, fb, fc;
    logic [12:0] tgt;
    logic [5:0]  pidx;
    logic [15:0] pval;
  } cmd_t;

  typedef struct {
    logic [12:0] net;
    logic [30:0] loss;
  } result_t;

  logic clk_i, rst_ni;
  logic start, busy, done_o;
  logic [1:0] opcode_i;
  logic signed [15:0] feature_a_i, feature_b_i, feature_c_i, param_value_i;
  logic [12:0] target_i, cfg_wdata_i, net_output_o;
  logic [5:0] param_index_i;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [30:0] loss_o;

  mlp_backprop_trainer DUT (.*);

  // testbench's copy of the network state
  longint sig_lut [256];
  longint w_in [NUM_WEIGHTS];
  longint w_out [NUM_HIDDEN];
  longint b_hid [NUM_HIDDEN];
  longint b_out;
  longint unsigned sq_err_sum;
  longint lr [4];

  cmd_t    cmd_q [$];
  result_t pending_results [$];
  int      idle_pct;
  int      n_err, n_checked, n_trains, cycles;

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // sigmoid table from integer powers of exp(-1/16) in Q30
  function automatic void build_lut();
    longint unsigned p, den;
    longint half [129];
    p = 64'd1 << 30;
    for (int k = 0; k <= 128; k++) begin
      den = (64'd1 << 30) + p;
      half[k] = longint'(((64'd4096 << 30) + den / 2) / den);
      p = (p * 64'd1008687096 + (64'd1 << 29)) >> 30;
    end
    for (int k = 0; k < 256; k++)
      sig_lut[k] = (k >= 128) ? half[k-128] : 4096 - half[128-k];
  endfunction

  function automatic longint rnd_sh(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint act(longint pre);
    if (pre < -32768) return sig_lut[0];
    if (pre > 32767) return sig_lut[255];
    return sig_lut[((pre + 32768) >>> 8) & 255];
  endfunction

  // forward pass plus optional SGD step, or a write or clear; returns the expected beat
  function automatic result_t net_step(cmd_t c);
    result_t r;
    longint x [3];
    longint h [NUM_HIDDEN];
    longint dh [NUM_HIDDEN];
    longint acc, y, diff, dq, k;
    x[0] = longint'($signed(c.fa));
    x[1] = longint'($signed(c.fb));
    x[2] = longint'($signed(c.fc));
    y = 0;
    if (c.op == OP_INFER || c.op == OP_TRAIN) begin
      for (int j = 0; j < NUM_HIDDEN; j++) begin
        acc = b_hid[j] * 4096;
        for (int i = 0; i < 3; i++) acc += w_in[i*NUM_HIDDEN + j] * x[i];
        h[j] = act(rnd_sh(acc, 12));
      end
      acc = b_out * 4096;
      for (int j = 0; j < NUM_HIDDEN; j++) acc += w_out[j] * h[j];
      y = act(rnd_sh(acc, 12));
    end
    if (c.op == OP_TRAIN) begin
      diff = longint'(c.tgt) - y;
      dq = rnd_sh(diff * y * (4096 - y), 24);
      // output layer first; hidden deltas see the updated output weights
      for (int j = 0; j < NUM_HIDDEN; j++)
        w_out[j] = clip16(w_out[j] + rnd_sh(lr[CFG_RATE_OW] * dq * h[j], 24));
      for (int j = 0; j < NUM_HIDDEN; j++) begin
        dh[j] = rnd_sh(dq * w_out[j] * (h[j] * (4096 - h[j])), 36);
        for (int i = 0; i < 3; i++) begin
          k = i * NUM_HIDDEN + j;
          w_in[k] = clip16(w_in[k] + rnd_sh(lr[CFG_RATE_HW] * dh[j] * x[i], 24));
        end
      end
      sq_err_sum += longint'(diff * diff);
      if (sq_err_sum > 64'hFFFF_FFFF) sq_err_sum = 64'hFFFF_FFFF;
      b_out = clip16(b_out + rnd_sh(lr[CFG_RATE_OB] * dq, 12));
      for (int j = 0; j < NUM_HIDDEN; j++)
        b_hid[j] = clip16(b_hid[j] + rnd_sh(lr[CFG_RATE_HB] * dh[j], 12));
    end else if (c.op == OP_WRITE) begin
      k = longint'(c.pidx);
      if (k < OW_BASE) w_in[k] = longint'($signed(c.pval));
      else if (k < HB_BASE) w_out[k - OW_BASE] = longint'($signed(c.pval));
      else if (k < OB_INDEX) b_hid[k - HB_BASE] = longint'($signed(c.pval));
      else if (k == OB_INDEX) b_out = longint'($signed(c.pval));
      // beyond the last parameter: ignored
    end else if (c.op == OP_CLEAR) begin
      sq_err_sum = 0;
    end
    r.net = 13'(y);
    r.loss = 31'(sq_err_sum >> 1);
    return r;
  endfunction

  // driver: a beat is taken when start is high and busy is low
  always @(posedge clk_i or negedge rst_ni) begin
    cmd_t c;
    if (!rst_ni) begin
      start <= 1'b0;
      opcode_i <= OP_INFER;
      feature_a_i <= '0;
      feature_b_i <= '0;
      feature_c_i <= '0;
      target_i <= '0;
      param_index_i <= '0;
      param_value_i <= '0;
    end else begin
      if (start && !busy) begin
        c.op = op_e'(opcode_i);
        c.fa = feature_a_i;
        c.fb = feature_b_i;
        c.fc = feature_c_i;
        c.tgt = target_i;
        c.pidx = param_index_i;
        c.pval = param_value_i;
        pending_results.push_back(net_step(c));
        if (c.op == OP_TRAIN) n_trains++;
      end
      if (!start || !busy) begin
        if (cmd_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          c = cmd_q.pop_front();
          opcode_i <= c.op;
          feature_a_i <= c.fa;
          feature_b_i <= c.fb;
          feature_c_i <= c.fc;
          target_i <= c.tgt;
          param_index_i <= c.pidx;
          param_value_i <= c.pval;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: done beats cannot be stalled, check each one as it shows
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected beat net=%0d loss=%0d", $time, net_output_o, loss_o);
        n_err++;
      end else begin
        e = pending_results.pop_front();
        n_checked++;
        if (net_output_o !== e.net) begin
          $display("%0t: net_output exp %0d got %0d", $time, e.net, net_output_o);
          n_err++;
        end
        if (loss_o !== e.loss) begin
          $display("%0t: loss exp %0d got %0d", $time, e.loss, loss_o);
          n_err++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d beats outstanding", $time, pending_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  function automatic cmd_t mk(op_e op, logic [15:0] fa, logic [15:0] fb, logic [15:0] fc,
                              logic [12:0] tgt, logic [5:0] pidx, logic [15:0] pval);
    cmd_t c;
    c.op = op; c.fa = fa; c.fb = fb; c.fc = fc;
    c.tgt = tgt; c.pidx = pidx; c.pval = pval;
    return c;
  endfunction

  // mostly small weights so training stays in the live part of the sigmoid
  function automatic logic [15:0] rnd_param();
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(8192)) - 4096);
  endfunction

  function automatic logic [15:0] rnd_feature();
    if ($urandom_range(4) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(16384)) - 8192);
  endfunction

  task automatic wait_idle();
    while (cmd_q.size() > 0 || start || pending_results.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_rates(logic [12:0] hw, logic [12:0] ow, logic [12:0] hb,
                             logic [12:0] ob);
    logic [12:0] v [4];
    v[0] = hw; v[1] = ow; v[2] = hb; v[3] = ob;
    for (int i = 0; i < 4; i++) begin
      @(posedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= cfg_idx_e'(i);
      cfg_wdata_i <= v[i];
      lr[i] = longint'(v[i]);
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_cmds(int n);
    int sel;
    repeat (n) begin
      sel = $urandom_range(99);
      if (sel < 55)
        cmd_q.push_back(mk(OP_TRAIN, rnd_feature(), rnd_feature(), rnd_feature(),
                           13'($urandom), 6'd0, 16'd0));
      else if (sel < 80)
        cmd_q.push_back(mk(OP_INFER, rnd_feature(), rnd_feature(), rnd_feature(),
                           13'($urandom), 6'($urandom), 16'($urandom)));
      else if (sel < 98)
        cmd_q.push_back(mk(OP_WRITE, 16'($urandom), 16'($urandom), 16'($urandom),
                           13'($urandom), 6'($urandom), rnd_param()));
      else
        cmd_q.push_back(mk(OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                           13'($urandom), 6'($urandom), 16'($urandom)));
    end
  endtask

  initial begin
    int ph_idle [4];
    build_lut();
    foreach (w_in[i]) w_in[i] = 0;
    foreach (w_out[i]) begin w_out[i] = 0; b_hid[i] = 0; end
    b_out = 0;
    sq_err_sum = 0;
    foreach (lr[i]) lr[i] = longint'(RATE_RESET);
    idle_pct = 0;
    n_err = 0; n_checked = 0; n_trains = 0; cycles = 0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_RATE_HW;
    cfg_wdata_i = '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every parameter gets a value before any forward pass may read it
    for (int i = 0; i < NUM_PARAMS; i++)
      cmd_q.push_back(mk(OP_WRITE, '0, '0, '0, '0, 6'(i), rnd_param()));
    // directed: field extremes, all opcodes, ignored index, big targets
    cmd_q.push_back(mk(OP_INFER, 16'h7FFF, 16'h7FFF, 16'h7FFF, 13'd0, 6'd0, 16'd0));
    cmd_q.push_back(mk(OP_INFER, 16'h8000, 16'h8000, 16'h8000, 13'd0, 6'd0, 16'd0));
    cmd_q.push_back(mk(OP_TRAIN, 16'h1000, 16'hF000, 16'h0000, 13'd4096, 6'd0, 16'd0));
    cmd_q.push_back(mk(OP_TRAIN, 16'h0800, 16'h0800, 16'h0800, 13'd0, 6'd0, 16'd0));
    cmd_q.push_back(mk(OP_TRAIN, 16'hFFFF, 16'h0001, 16'h8000, 13'h1FFF, 6'd0, 16'd0));
    cmd_q.push_back(mk(OP_WRITE, '0, '0, '0, '0, 6'd63, 16'h7FFF));
    cmd_q.push_back(mk(OP_WRITE, '0, '0, '0, '0, 6'd51, 16'h8000));
    cmd_q.push_back(mk(OP_CLEAR, '0, '0, '0, '0, '0, '0));
    cmd_q.push_back(mk(OP_WRITE, '0, '0, '0, '0, 6'(OB_INDEX), 16'h7FFF));
    cmd_q.push_back(mk(OP_WRITE, '0, '0, '0, '0, 6'(OW_BASE), 16'h8000));
    cmd_q.push_back(mk(OP_INFER, 16'h0000, 16'h0000, 16'h0000, 13'd0, 6'd0, 16'd0));
    // pin the output near zero, then drive the error sum into saturation
    // with far-off targets (each step adds close to 8190 squared)
    for (int j = 0; j < NUM_HIDDEN; j++)
      cmd_q.push_back(mk(OP_WRITE, '0, '0, '0, '0, 6'(OW_BASE + j), 16'h0000));
    cmd_q.push_back(mk(OP_WRITE, '0, '0, '0, '0, 6'(OB_INDEX), 16'h8000));
    repeat (70)
      cmd_q.push_back(mk(OP_TRAIN, rnd_feature(), rnd_feature(), rnd_feature(),
                         13'h1FFF, 6'd0, 16'd0));
    cmd_q.push_back(mk(OP_INFER, 16'h0100, 16'h0200, 16'h0300, 13'd0, 6'd0, 16'd0));
    cmd_q.push_back(mk(OP_CLEAR, '0, '0, '0, '0, '0, '0));
    wait_idle();

    // phases: rates and sender idle percentage per phase
    ph_idle[0] = 0; ph_idle[1] = 88; ph_idle[2] = 0; ph_idle[3] = 16;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_rates(RATE_RESET, RATE_RESET, RATE_RESET, RATE_RESET);
        1: write_rates(13'd0, 13'd0, 13'd0, 13'd0);
        2: write_rates(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF);
        default: write_rates(13'($urandom), 13'($urandom), 13'($urandom), 13'($urandom));
      endcase
      idle_pct = ph_idle[ph];
      random_cmds(ITEMS_PER_PHASE);
      wait_idle();
    end

    $display("Checked %0d result beats (%0d training steps) over 4 rate settings",
             n_checked, n_trains);
    $display("Sender idling of 0, 16 and 88 percent; %0d mismatches", n_err);
    if (n_err == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
